// ----- hdl/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// tli_pkg
// Shared constants and types of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DATA_W          = 32;
  localparam int INDEX_W         = 8;
  localparam int PTS_W           = 9;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(2);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register select is paddr bit 2.
  localparam logic REG_POINTS  = 1'b0;
  localparam logic REG_COMPLEX = 1'b1;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W:0]   dx;
    logic signed [DATA_W:0]   tx;
  } lerp_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } lerp_rsp_t;

endpackage

// ----- hdl/tli_ifaces.sv -----
// ----------------------------------------------------------------------------
// tli_ifaces
// Sample/load channel and result channel of the table linear interpolator.
// ----------------------------------------------------------------------------
interface tli_item_if import tli_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [INDEX_W-1:0]        point_index;
  logic signed [DATA_W-1:0]  point_x;
  logic signed [DATA_W-1:0]  point_y_real;
  logic signed [DATA_W-1:0]  point_y_imag;
  logic signed [DATA_W-1:0]  sample;
  logic                      last_sample;

  modport source (output valid, cmd, point_index, point_x, point_y_real, point_y_imag,
                  sample, last_sample, input ready);
  modport sink (input valid, cmd, point_index, point_x, point_y_real, point_y_imag,
                sample, last_sample, output ready);
endinterface

interface tli_result_if import tli_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  result_real;
  logic signed [DATA_W-1:0]  result_imag;
  logic                      flat_segment;
  logic                      saturated;
  logic                      batch_end;

  modport source (output valid, result_real, result_imag, flat_segment, saturated,
                  batch_end, input ready);
  modport sink (input valid, result_real, result_imag, flat_segment, saturated,
                batch_end, output ready);
endinterface

// ----- hdl/tli_ram.sv -----
// ----------------------------------------------------------------------------
// tli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tli_lerp.sv -----
// ----------------------------------------------------------------------------
// tli_lerp
// Bit-serial y0 + round((y1 - y0) * dx / tx) with saturation to 32 bits.
// ----------------------------------------------------------------------------
module tli_lerp import tli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lerp_req_t req,
  output lerp_rsp_t rsp
);

  localparam int MW        = DATA_W + 1;
  localparam int PW        = 2 * MW;
  localparam int MUL_STEPS = MW;
  localparam int DIV_STEPS = PW;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIN  = 4'b1000
  } lstate_t;

  lstate_t                  state;
  logic [CNT_W-1:0]         cnt;
  logic [MW-1:0]            hi;
  logic [MW-1:0]            lo;
  logic [MW-1:0]            amag;
  logic [MW-1:0]            atx;
  logic [PW-1:0]            num;
  logic [MW-1:0]            rem;
  logic                     neg;
  logic                     add_done;
  logic signed [DATA_W-1:0] y0;

  logic signed [MW-1:0] dy;
  logic [MW:0]          msum;
  logic [MW:0]          trial;
  logic [MW+1:0]        diff;
  logic                 ge;
  logic                 big;
  logic signed [DATA_W+2:0] fsum;

  always_comb begin
    dy    = MW'(req.y1) - MW'(req.y0);
    msum  = {1'b0, hi} + (lo[0] ? {1'b0, amag} : '0);
    trial = {rem, num[PW-1]};
    diff  = {1'b0, trial} - {2'b0, atx};
    ge    = !diff[MW+1];
    big   = num > (PW'(1) << (DATA_W + 1));
    fsum  = neg ? ((DATA_W+3)'(y0) - (DATA_W+3)'({1'b0, num[DATA_W+1:0]}))
                : ((DATA_W+3)'(y0) + (DATA_W+3)'({1'b0, num[DATA_W+1:0]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            amag  <= dy[MW-1] ? MW'(-dy) : MW'(dy);
            lo    <= req.dx[MW-1] ? MW'(-req.dx) : MW'(req.dx);
            atx   <= req.tx[MW-1] ? MW'(-req.tx) : MW'(req.tx);
            neg   <= dy[MW-1] ^ req.dx[MW-1] ^ req.tx[MW-1];
            y0    <= req.y0;
            hi    <= '0;
            cnt   <= '0;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          hi  <= msum[MW:1];
          lo  <= {msum[0], lo[MW-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            add_done <= 1'b0;
            state    <= L_DIV;
          end
        end
        L_DIV: begin
          if (!add_done) begin
            num      <= {hi, lo} + PW'(atx >> 1);
            rem      <= '0;
            cnt      <= '0;
            add_done <= 1'b1;
          end else begin
            rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
            num <= {num[PW-2:0], ge};
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(DIV_STEPS - 1)) begin
              state <= L_FIN;
            end
          end
        end
        L_FIN: begin
          rsp.done <= 1'b1;
          if (big) begin
            rsp.sat   <= 1'b1;
            rsp.value <= neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
          end else if (fsum[DATA_W+2:DATA_W-1] != {4{fsum[DATA_W-1]}}) begin
            rsp.sat   <= 1'b1;
            rsp.value <= fsum[DATA_W+2] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
          end else begin
            rsp.sat   <= 1'b0;
            rsp.value <= fsum[DATA_W-1:0];
          end
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear calibration of samples through a loadable breakpoint table.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  items     in         load one breakpoint (cmd 0) or interpolate a sample
//  results   out        one interpolated value per sample
//  apb       in         points_in_use at 0x0, complex_values at 0x4
//
// A load is written to the table when it is accepted. A sample is accepted,
// then compared against the segments in the search; its segment is fetched,
// each interpolated part of a non-flat segment passes through the shared serial
// multiply/divide unit (multiply, then divide), and the result is presented.
// Reset clears the remembered segment and resets the registers; the table is not
// cleared. A stalled result holds the block in its final state.
module table_linear_interpolator import tli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  tli_item_if.sink           items,
  tli_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = (AW + 1 > PTS_W) ? AW + 1 : PTS_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_CMP  = 11'b00000000100,
    S_F0   = 11'b00000001000,
    S_F1   = 11'b00000010000,
    S_F2   = 11'b00000100000,
    S_CALC = 11'b00001000000,
    S_WR   = 11'b00010000000,
    S_SI   = 11'b00100000000,
    S_WI   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t             state;
  logic [PTS_W-1:0]   points_in_use;
  logic               complex_values;
  logic [AW-1:0]      seg;
  logic [AW-1:0]      nm2;
  logic               up_phase;
  logic signed [DATA_W-1:0] x_s;
  logic               last_s;
  logic signed [DATA_W-1:0] x0, x1, yr0, yr1, yi0, yi1;
  logic signed [DATA_W-1:0] rr, ri;
  logic               flat, sat;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;
  logic [DATA_W-1:0]  rx, ryr, ryi;
  logic signed [DATA_W-1:0] d;
  logic [CW-1:0]      pts_ext;
  logic [CW-1:0]      n_eff;
  logic [AW-1:0]      nm2_c;
  logic signed [DATA_W:0] tx, dx;
  logic               accept;
  lerp_req_t          req;
  lerp_rsp_t          rsp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COMPLEX) ? PDATA_W'(complex_values)
                                            : PDATA_W'(points_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use  <= PTS_RESET;
      complex_values <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_COMPLEX) begin
        complex_values <= pwdata[0];
      end else begin
        points_in_use <= pwdata[PTS_W-1:0];
      end
    end
  end

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign we          = accept && (items.cmd == CMD_LOAD) &&
                       (32'(items.point_index) < TABLE_DEPTH);
  assign waddr       = AW'(items.point_index);
  assign raddr       = (state == S_F1) ? seg + 1'b1 : seg;
  assign d           = $signed(rx);

  always_comb begin
    pts_ext = CW'(points_in_use);
    if (pts_ext < CW'(2)) begin
      n_eff = CW'(2);
    end else if (pts_ext > CW'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = pts_ext;
    end
    nm2_c = AW'(n_eff - CW'(2));
    tx    = (DATA_W+1)'(x1) - (DATA_W+1)'(x0);
    dx    = (DATA_W+1)'(x_s) - (DATA_W+1)'(x0);
    req.start = (state == S_CALC && tx != '0) || (state == S_SI);
    req.y0    = (state == S_SI) ? yi0 : yr0;
    req.y1    = (state == S_SI) ? yi1 : yr1;
    req.dx    = dx;
    req.tx    = tx;
  end

  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(items.point_x), .raddr(raddr), .rdata(rx)
  );
  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_yr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(items.point_y_real), .raddr(raddr),
    .rdata(ryr)
  );
  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram_yi (
    .clk(clk), .we(we), .waddr(waddr), .wdata(items.point_y_imag), .raddr(raddr),
    .rdata(ryi)
  );

  tli_lerp u_lerp (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_OUT) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && items.cmd == CMD_SAMPLE) begin
            seg      <= (seg > nm2_c) ? nm2_c : seg;
            nm2      <= nm2_c;
            x_s      <= items.sample;
            last_s   <= items.last_sample;
            up_phase <= 1'b1;
            state    <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (up_phase && seg < nm2 && x_s > d) begin
            seg   <= seg + 1'b1;
            state <= S_RD;
          end else if (seg != '0 && x_s < d) begin
            seg      <= seg - 1'b1;
            up_phase <= 1'b0;
            state    <= S_RD;
          end else begin
            state <= S_F0;
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          x0    <= $signed(rx);
          yr0   <= $signed(ryr);
          yi0   <= $signed(ryi);
          state <= S_F2;
        end
        S_F2: begin
          x1    <= $signed(rx);
          yr1   <= $signed(ryr);
          yi1   <= $signed(ryi);
          state <= S_CALC;
        end
        S_CALC: begin
          if (tx == '0) begin
            rr    <= yr0;
            ri    <= complex_values ? yi0 : '0;
            flat  <= 1'b1;
            sat   <= 1'b0;
            state <= S_OUT;
          end else begin
            flat  <= 1'b0;
            state <= S_WR;
          end
        end
        S_WR: begin
          if (rsp.done) begin
            rr  <= rsp.value;
            sat <= rsp.sat;
            ri  <= '0;
            state <= complex_values ? S_SI : S_OUT;
          end
        end
        S_SI: state <= S_WI;
        S_WI: begin
          if (rsp.done) begin
            ri    <= rsp.value;
            sat   <= sat | rsp.sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid        <= 1'b1;
            results.result_real  <= rr;
            results.result_imag  <= ri;
            results.flat_segment <= flat;
            results.saturated    <= sat;
            results.batch_end    <= last_s;
            if (last_s) begin
              seg <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/tli_checker.sv -----
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table linear interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tli_checker import tli_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_real,
  input logic [DATA_W-1:0] out_imag
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_real) && $stable(out_imag))
    else $error("result payload changed while stalled");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_SAMPLE |=> !in_ready)
    else $error("sample transaction did not occupy the block");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(items.valid),
  .in_ready(items.ready),
  .in_cmd(items.cmd),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_real(results.result_real),
  .out_imag(results.result_imag)
);
